@@ hdl/lidar_express_capsule_decoder_unit_macros.svh @@
// assertion macros shared by the capsule decoder modules
`ifndef LIDAR_EXPRESS_CAPSULE_DECODER_UNIT_MACROS_SVH
`define LIDAR_EXPRESS_CAPSULE_DECODER_UNIT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define LECD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the cycle after the trigger
`define LECD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lecd_pkg.sv @@
package lecd_pkg;

	// capsule layout
	localparam int CAPSULE_BYTES = 84;
	localparam int HDR_BYTES     = 4;
	localparam int CABIN_BYTES   = 5;

	// fixed field widths
	localparam int ANGLE_W = 15;
	localparam int DIST_W  = 14;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 14;
	localparam int ACC_W   = 24;
	localparam int STEP_W  = 17;
	localparam int ARAW_W  = 18;

	// time and angle steps are spread over 32 samples
	localparam int STEP_SHIFT = 5;

	// full turn in degrees times 64, and twice that
	localparam logic [16:0] FULL_Q6  = 17'd23040;
	localparam logic [16:0] FULL2_Q6 = 17'd46080;
	localparam logic signed [STEP_W-1:0] FULL_RAW = 17'sd23040;

	// capsules that must be stored before decoding starts
	localparam logic [1:0] SEEN_DECODE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] CFG_MIN_DIST    = 2'd2;
	localparam logic [1:0] CFG_MAX_DIST    = 2'd3;

	// configuration reset values
	localparam logic [3:0]        SYNC_FIRST_RST  = 4'd10;
	localparam logic [3:0]        SYNC_SECOND_RST = 4'd5;
	localparam logic [DIST_W-1:0] MIN_DIST_RST    = 14'd0;
	localparam logic [DIST_W-1:0] MAX_DIST_RST    = 14'd16383;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic rd_en;
		logic sample;
		logic emit;
	} lecd_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic decode_due;
		logic fetch_last;
		logic samp_odd;
		logic samp_last;
		logic out_free;
	} lecd_sts_t;

endpackage

@@ hdl/lidar_express_capsule_decoder_unit.sv @@
// Express-scan capsule decoder. Bytes come in one per transaction with their arrival time and
// are gathered into 84-byte capsules in a two-bank 168-byte single-port memory; the first two
// bytes must carry the configured sync nibbles, otherwise the byte is dropped and assembly
// restarts. While no capsule is being decoded a byte is taken every cycle. When the third or any
// later capsule completes, the input stalls while the capsule before it is read back and turned
// into 32 samples: each of the 16 cabins takes 5 memory reads and a drain state for the last read
// to land, then each sample passes a sample state (angle step) and an emit state (angle reduction
// into the output register) that waits while the output is held off. The memory needs no
// clearing pass after reset.
module lidar_express_capsule_decoder_unit #(
	parameter int CAPSULE_BYTES = lecd_pkg::CAPSULE_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      rx_byte,
	input  logic [lecd_pkg::TIME_W-1:0]     time_us,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lecd_pkg::ANGLE_W-1:0]    sample_angle,
	output logic [lecd_pkg::DIST_W-1:0]     distance_q2,
	output logic [lecd_pkg::TIME_W-1:0]     sample_time_us,
	output logic                            in_range,
	output logic                            last,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [lecd_pkg::CFG_W-1:0]      cfg_data
);

	lecd_pkg::lecd_cmd_t cmd;
	lecd_pkg::lecd_sts_t sts;

	// sequencer
	lecd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// assembly memory, decode arithmetic and output register
	lecd_datapath #(
		.CAPSULE_BYTES (CAPSULE_BYTES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.rx_byte        (rx_byte),
		.time_us        (time_us),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_angle   (sample_angle),
		.distance_q2    (distance_q2),
		.sample_time_us (sample_time_us),
		.in_range       (in_range),
		.last           (last)
	);

endmodule

@@ hdl/lecd_ctrl.sv @@
`include "lidar_express_capsule_decoder_unit_macros.svh"

module lecd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lecd_pkg::lecd_sts_t sts,
	output lecd_pkg::lecd_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FETCH  = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_SAMPLE = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// command decode
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cmd.accept = in_ready && in_valid;
		cmd.rd_en  = (state_q == S_FETCH);
		cmd.sample = (state_q == S_SAMPLE);
		cmd.emit   = (state_q == S_EMIT) && sts.out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept && sts.decode_due) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				if (sts.fetch_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_SAMPLE;
			end
			S_SAMPLE: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					if (sts.samp_last) begin
						state_d = S_IDLE;
					end else if (sts.samp_odd) begin
						state_d = S_FETCH;
					end else begin
						state_d = S_SAMPLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`LECD_ASSERT_NEXT(a_decode_stalls_input, cmd.accept && sts.decode_due, !in_ready, "input not stalled at decode start")
	`LECD_ASSERT_NEXT(a_last_emit_idles, cmd.emit && sts.samp_last, in_ready, "no return to idle after last sample")
	`LECD_ASSERT_NOW(a_read_while_stalled, cmd.rd_en, !in_ready, "memory read while input is open")

endmodule

@@ hdl/lecd_datapath.sv @@
`include "lidar_express_capsule_decoder_unit_macros.svh"

module lecd_datapath #(
	parameter int CAPSULE_BYTES = lecd_pkg::CAPSULE_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lecd_pkg::lecd_cmd_t             cmd,
	output lecd_pkg::lecd_sts_t             sts,
	input  logic [7:0]                      rx_byte,
	input  logic [lecd_pkg::TIME_W-1:0]     time_us,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [lecd_pkg::CFG_W-1:0]      cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lecd_pkg::ANGLE_W-1:0]    sample_angle,
	output logic [lecd_pkg::DIST_W-1:0]     distance_q2,
	output logic [lecd_pkg::TIME_W-1:0]     sample_time_us,
	output logic                            in_range,
	output logic                            last
);

	localparam int CNT_W     = $clog2(CAPSULE_BYTES);
	localparam int MEM_DEPTH = 2 * CAPSULE_BYTES;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int CABINS    = (CAPSULE_BYTES - lecd_pkg::HDR_BYTES) / lecd_pkg::CABIN_BYTES;
	localparam int SAMPLES   = 2 * CABINS;
	localparam int SAMP_W    = $clog2(SAMPLES);
	localparam int SLOT_W    = $clog2(lecd_pkg::CABIN_BYTES);
	localparam int TSTEP_W   = lecd_pkg::TIME_W - lecd_pkg::STEP_SHIFT;
	localparam int DIST_W    = lecd_pkg::DIST_W;
	localparam int ACC_W     = lecd_pkg::ACC_W;
	localparam int STEP_W    = lecd_pkg::STEP_W;
	localparam int ARAW_W    = lecd_pkg::ARAW_W;

	// configuration registers
	logic [3:0]        sync_first_q;
	logic [3:0]        sync_second_q;
	logic [DIST_W-1:0] min_dist_q;
	logic [DIST_W-1:0] max_dist_q;

	// assembly state
	logic [CNT_W-1:0]                cnt_q;
	logic                            bank_q;
	logic [1:0]                      seen_q;
	logic [7:0]                      cur_lo_q;
	logic [6:0]                      cur_hi_q;
	logic [lecd_pkg::ANGLE_W-1:0]    prv_ang_q;
	logic [lecd_pkg::TIME_W-1:0]     prev_time_q;
	logic [lecd_pkg::TIME_W-1:0]     older_time_q;

	// decode state
	logic signed [STEP_W-1:0]        step_q;
	logic signed [ACC_W-1:0]         acc_q;
	logic [lecd_pkg::TIME_W-1:0]     t_q;
	logic [TSTEP_W-1:0]              tstep_q;
	logic [CNT_W-1:0]                rd_idx_q;
	logic [SLOT_W-1:0]               slot_q;
	logic                            cap_en_q;
	logic [SLOT_W-1:0]               cap_slot_q;
	logic [7:0]                      rd_data_q;
	logic [7:0]                      cab_q [0:lecd_pkg::CABIN_BYTES-1];
	logic [SAMP_W-1:0]               samp_q;
	logic [7:0]                      mem_q [0:MEM_DEPTH-1];

	// sample stage
	logic signed [ARAW_W-1:0]        angle_s1;
	logic [DIST_W-1:0]               dist_s1;
	logic [lecd_pkg::TIME_W-1:0]     time_s1;
	logic                            last_s1;

	// output register
	logic                            out_valid_q;
	logic [lecd_pkg::ANGLE_W-1:0]    angle_q;
	logic [DIST_W-1:0]               dist_q;
	logic [lecd_pkg::TIME_W-1:0]     time_q;
	logic                            in_range_q;
	logic                            last_q;

	logic                            drop;
	logic                            mem_we;
	logic                            cap_end;
	logic [ADDR_W-1:0]               waddr;
	logic [ADDR_W-1:0]               raddr;
	logic [lecd_pkg::ANGLE_W-1:0]    cur_raw;
	logic signed [STEP_W-1:0]        ang_diff;
	logic signed [STEP_W-1:0]        step_d;
	logic [5:0]                      off;
	logic [DIST_W-1:0]               cab_dist;
	logic [16:0]                     ang_pos;
	logic [lecd_pkg::ANGLE_W-1:0]    ang_norm;

	// sync check and capsule completion
	always_comb begin
		drop = ((cnt_q == '0) && (rx_byte[7:4] != sync_first_q)) ||
			((cnt_q == CNT_W'(1)) && (rx_byte[7:4] != sync_second_q));
		mem_we  = cmd.accept && !drop;
		cap_end = (cnt_q == CNT_W'(CAPSULE_BYTES - 1));
		waddr   = bank_q ? ADDR_W'(CAPSULE_BYTES) + ADDR_W'(cnt_q) : ADDR_W'(cnt_q);
		raddr   = bank_q ? ADDR_W'(CAPSULE_BYTES) + ADDR_W'(rd_idx_q) : ADDR_W'(rd_idx_q);
	end

	// start angle step between the previous capsule and the new one
	always_comb begin
		cur_raw  = {cur_hi_q, cur_lo_q};
		ang_diff = $signed({2'b00, cur_raw}) - $signed({2'b00, prv_ang_q});
		step_d   = (prv_ang_q > cur_raw) ? ang_diff + lecd_pkg::FULL_RAW : ang_diff;
	end

	// status to controller
	always_comb begin
		sts.decode_due = cap_end && (seen_q == lecd_pkg::SEEN_DECODE);
		sts.fetch_last = (slot_q == SLOT_W'(lecd_pkg::CABIN_BYTES - 1));
		sts.samp_odd   = samp_q[0];
		sts.samp_last  = (samp_q == SAMP_W'(SAMPLES - 1));
		sts.out_free   = !out_valid_q || out_ready;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= lecd_pkg::SYNC_FIRST_RST;
			sync_second_q <= lecd_pkg::SYNC_SECOND_RST;
			min_dist_q    <= lecd_pkg::MIN_DIST_RST;
			max_dist_q    <= lecd_pkg::MAX_DIST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lecd_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_data[3:0];
				lecd_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_data[3:0];
				lecd_pkg::CFG_MIN_DIST:    min_dist_q    <= cfg_data[DIST_W-1:0];
				lecd_pkg::CFG_MAX_DIST:    max_dist_q    <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// byte assembly, bank swap and capsule time stamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			bank_q       <= 1'b0;
			seen_q       <= '0;
			prev_time_q  <= '0;
			older_time_q <= '0;
		end else if (cmd.accept) begin
			if (drop) begin
				cnt_q <= '0;
			end else if (cap_end) begin
				cnt_q        <= '0;
				bank_q       <= !bank_q;
				older_time_q <= prev_time_q;
				prev_time_q  <= time_us;
				if (seen_q != lecd_pkg::SEEN_DECODE) begin
					seen_q <= seen_q + 2'd1;
				end
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// start angle bytes of the capsule being assembled
	always_ff @(posedge clk) begin
		if (mem_we && (cnt_q == CNT_W'(2))) begin
			cur_lo_q <= rx_byte;
		end
		if (mem_we && (cnt_q == CNT_W'(3))) begin
			cur_hi_q <= rx_byte[6:0];
		end
	end

	// decode setup at capsule end, then per-sample stepping
	always_ff @(posedge clk) begin
		if (mem_we && cap_end) begin
			prv_ang_q <= cur_raw;
			step_q    <= step_d;
			acc_q     <= $signed({4'b0000, prv_ang_q, 5'b00000});
			t_q       <= prev_time_q;
			tstep_q   <= TSTEP_W'((prev_time_q - older_time_q) >> lecd_pkg::STEP_SHIFT);
		end else if (cmd.sample) begin
			acc_q <= acc_q + {{(ACC_W - STEP_W){step_q[STEP_W-1]}}, step_q};
			t_q   <= t_q + {{lecd_pkg::STEP_SHIFT{1'b0}}, tstep_q};
		end
	end

	// read pointer, cabin slot and sample counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= CNT_W'(lecd_pkg::HDR_BYTES);
			slot_q     <= '0;
			cap_en_q   <= 1'b0;
			cap_slot_q <= '0;
			samp_q     <= '0;
		end else begin
			cap_en_q   <= cmd.rd_en;
			cap_slot_q <= slot_q;
			if (mem_we && cap_end) begin
				rd_idx_q <= CNT_W'(lecd_pkg::HDR_BYTES);
				slot_q   <= '0;
				samp_q   <= '0;
			end else begin
				if (cmd.rd_en) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
					slot_q   <= sts.fetch_last ? '0 : slot_q + SLOT_W'(1);
				end
				if (cmd.emit) begin
					samp_q <= samp_q + SAMP_W'(1);
				end
			end
		end
	end

	// two-bank capsule memory, one access per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	// cabin byte capture
	always_ff @(posedge clk) begin
		if (cap_en_q) begin
			cab_q[cap_slot_q] <= rd_data_q;
		end
	end

	// cabin field extraction for the current sample
	always_comb begin
		if (samp_q[0]) begin
			off      = {cab_q[2][1:0], cab_q[4][7:4]};
			cab_dist = {cab_q[3], cab_q[2][7:2]};
		end else begin
			off      = {cab_q[0][1:0], cab_q[4][3:0]};
			cab_dist = {cab_q[1], cab_q[0][7:2]};
		end
	end

	// sample stage: interpolated angle minus the offset
	always_ff @(posedge clk) begin
		if (cmd.sample) begin
			angle_s1 <= $signed({1'b0, acc_q[21:5]}) - $signed({9'b0, off, 3'b000});
			dist_s1  <= cab_dist;
			time_s1  <= t_q;
			last_s1  <= (samp_q == SAMP_W'(SAMPLES - 1));
		end
	end

	// angle reduction into one turn
	always_comb begin
		ang_pos = angle_s1[ARAW_W-1] ? angle_s1[16:0] + lecd_pkg::FULL_Q6 : angle_s1[16:0];
		if (ang_pos >= lecd_pkg::FULL2_Q6) begin
			ang_norm = lecd_pkg::ANGLE_W'(ang_pos - lecd_pkg::FULL2_Q6);
		end else if (ang_pos >= lecd_pkg::FULL_Q6) begin
			ang_norm = lecd_pkg::ANGLE_W'(ang_pos - lecd_pkg::FULL_Q6);
		end else begin
			ang_norm = ang_pos[lecd_pkg::ANGLE_W-1:0];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			angle_q    <= ang_norm;
			dist_q     <= dist_s1;
			time_q     <= time_s1;
			in_range_q <= (dist_s1 >= min_dist_q) && (dist_s1 <= max_dist_q);
			last_q     <= last_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign sample_angle   = angle_q;
	assign distance_q2    = dist_q;
	assign sample_time_us = time_q;
	assign in_range       = in_range_q;
	assign last           = last_q;

	`LECD_ASSERT_NOW(a_no_read_on_write, mem_we, !cmd.rd_en, "memory read and write in one cycle")
	`LECD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q < CNT_W'(CAPSULE_BYTES), "byte count past capsule end")
	`LECD_ASSERT_NOW(a_read_in_capsule, cmd.rd_en, rd_idx_q < CNT_W'(CAPSULE_BYTES), "read past capsule end")

endmodule

@@ sim/capsule_decode_tracker_pkg.sv @@
package capsule_decode_tracker_pkg;
	import lecd_pkg::*;

	// capsule geometry and angle scale
	localparam int CABIN_COUNT = (CAPSULE_BYTES - HDR_BYTES) / CABIN_BYTES;
	localparam int SAMPLES_PER_CAPSULE = 2 * CABIN_COUNT;
	localparam longint TURN_Q8 = 360 << 8;
	localparam longint TURN_Q6 = 360 << 6;
	localparam int REPORT_LIMIT = 10;

	// one decoded sample as it leaves the block
	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic [DIST_W-1:0]  distance;
		logic [TIME_W-1:0]  stamp;
		logic               in_range;
		logic               last;
	} sample_t;

	// follows capsule assembly and holds the samples the block owes us
	class capsule_decode_tracker;
		int unsigned        fill;
		logic [7:0]         asm_bytes [CAPSULE_BYTES];
		logic [7:0]         prev_cap [CAPSULE_BYTES];
		int                 stored;
		logic [TIME_W-1:0]  prev_time;
		logic [TIME_W-1:0]  older_time;
		logic [3:0]         sync_a;
		logic [3:0]         sync_b;
		logic [DIST_W-1:0]  dist_min;
		logic [DIST_W-1:0]  dist_max;
		sample_t            expected_samples [$];
		int                 mismatch_count;

		function new();
			fill = 0;
			stored = 0;
			prev_time = '0;
			older_time = '0;
			sync_a = SYNC_FIRST_RST;
			sync_b = SYNC_SECOND_RST;
			dist_min = MIN_DIST_RST;
			dist_max = MAX_DIST_RST;
			mismatch_count = 0;
		endfunction

		function void set_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
			case (idx)
				CFG_SYNC_FIRST: sync_a = value[3:0];
				CFG_SYNC_SECOND: sync_b = value[3:0];
				CFG_MIN_DIST: dist_min = value[DIST_W-1:0];
				CFG_MAX_DIST: dist_max = value[DIST_W-1:0];
				default: ;
			endcase
		endfunction

		// turn the stored capsule into its samples, using the new start angle
		function void decode_previous();
			longint            cur_q8;
			longint            prv_q8;
			longint            step_q16;
			longint            acc_q16;
			longint            ang;
			logic [TIME_W-1:0] tstep;
			logic [TIME_W-1:0] stamp;
			logic [DIST_W-1:0] dists [2];
			logic [5:0]        offs [2];
			int                base;
			int                n;
			sample_t           s;
			cur_q8 = longint'({asm_bytes[3][6:0], asm_bytes[2]});
			prv_q8 = longint'({prev_cap[3][6:0], prev_cap[2]});
			cur_q8 = cur_q8 * 4;
			prv_q8 = prv_q8 * 4;
			step_q16 = cur_q8 - prv_q8;
			// backward start angle means the turn wrapped
			if (prv_q8 > cur_q8) begin
				step_q16 = step_q16 + TURN_Q8;
			end
			step_q16 = step_q16 * 8;
			acc_q16 = prv_q8 * 256;
			tstep = (prev_time - older_time) >> STEP_SHIFT;
			stamp = prev_time;
			n = 0;
			for (int c = 0; c < CABIN_COUNT; c++) begin
				base = c * CABIN_BYTES + HDR_BYTES;
				dists[0] = {prev_cap[base + 1], prev_cap[base][7:2]};
				dists[1] = {prev_cap[base + 3], prev_cap[base + 2][7:2]};
				offs[0] = {prev_cap[base][1:0], prev_cap[base + 4][3:0]};
				offs[1] = {prev_cap[base + 2][1:0], prev_cap[base + 4][7:4]};
				for (int k = 0; k < 2; k++) begin
					// arithmetic shift gives the floor of the division
					ang = (acc_q16 - longint'(offs[k]) * 8192) >>> 10;
					acc_q16 = acc_q16 + step_q16;
					ang = ang % TURN_Q6;
					if (ang < 0) begin
						ang = ang + TURN_Q6;
					end
					s.angle = ang[ANGLE_W-1:0];
					s.distance = dists[k];
					s.stamp = stamp;
					s.in_range = (dists[k] >= dist_min) && (dists[k] <= dist_max);
					s.last = (n == SAMPLES_PER_CAPSULE - 1);
					expected_samples.push_back(s);
					stamp = stamp + tstep;
					n++;
				end
			end
		endfunction

		// one accepted input transaction
		function void note_byte(input logic [7:0] rx, input logic [TIME_W-1:0] at_us);
			if ((fill == 0 && rx[7:4] != sync_a) || (fill == 1 && rx[7:4] != sync_b)) begin
				fill = 0;
				return;
			end
			asm_bytes[fill] = rx;
			fill++;
			if (fill < CAPSULE_BYTES) begin
				return;
			end
			fill = 0;
			if (stored >= SEEN_DECODE) begin
				decode_previous();
			end else begin
				stored++;
			end
			prev_cap = asm_bytes;
			older_time = prev_time;
			prev_time = at_us;
		endfunction

		// one accepted output transaction
		function void check_sample(input sample_t got);
			sample_t want;
			if (expected_samples.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("unexpected sample: angle %0d distance %0d time %0h in_range %0b last %0b",
						got.angle, got.distance, got.stamp, got.in_range, got.last);
				end
				return;
			end
			want = expected_samples.pop_front();
			if (got.angle !== want.angle || got.distance !== want.distance ||
					got.stamp !== want.stamp || got.in_range !== want.in_range ||
					got.last !== want.last) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("sample mismatch: expected angle %0d distance %0d time %0h in_range %0b last %0b",
						want.angle, want.distance, want.stamp, want.in_range, want.last);
					$display("                 actual   angle %0d distance %0d time %0h in_range %0b last %0b",
						got.angle, got.distance, got.stamp, got.in_range, got.last);
				end
			end
		endfunction
	endclass

endpackage

@@ sim/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lecd_pkg::*;
	import capsule_decode_tracker_pkg::*;

	localparam int QUIET_CYCLES = 250;
	localparam int LIMIT_CYCLES = 400000;
	localparam int JUNK_PICKS = 8;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          rx_byte = '0;
	logic [TIME_W-1:0]   time_us = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [ANGLE_W-1:0]  sample_angle;
	logic [DIST_W-1:0]   distance_q2;
	logic [TIME_W-1:0]   sample_time_us;
	logic                in_range;
	logic                last;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_index = CFG_SYNC_FIRST;
	logic [CFG_W-1:0]    cfg_data = '0;

	capsule_decode_tracker tracker = new();
	logic [7:0]            cap_buf [CAPSULE_BYTES];
	logic [TIME_W-1:0]     now_us = '0;
	int                    send_idle_pct = 0;
	int                    recv_stall_pct = 0;
	int                    cycle_count = 0;

	lidar_express_capsule_decoder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.time_us        (time_us),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_angle   (sample_angle),
		.distance_q2    (distance_q2),
		.sample_time_us (sample_time_us),
		.in_range       (in_range),
		.last           (last),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watch both channels in one place so inputs are noted before results are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				tracker.note_byte(rx_byte, time_us);
			end
			if (out_valid && out_ready) begin
				tracker.check_sample({sample_angle, distance_q2, sample_time_us, in_range, last});
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// one input transaction, with optional idle cycles ahead of it
	task automatic send_byte(input logic [7:0] value, input logic [TIME_W-1:0] at_us);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= value;
		time_us <= at_us;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// random capsule body with valid sync nibbles and a given start angle
	task automatic build_capsule(input logic [14:0] angle_raw);
		for (int i = 0; i < CAPSULE_BYTES; i++) begin
			cap_buf[i] = 8'($urandom());
		end
		cap_buf[0] = {tracker.sync_a, cap_buf[0][3:0]};
		cap_buf[1] = {tracker.sync_b, cap_buf[1][3:0]};
		cap_buf[2] = angle_raw[7:0];
		cap_buf[3] = {cap_buf[3][7], angle_raw[14:8]};
	endtask

	task automatic send_capsule();
		for (int i = 0; i < CAPSULE_BYTES; i++) begin
			send_byte(cap_buf[i], now_us);
			now_us = now_us + $urandom_range(120, 40);
		end
	endtask

	// a byte that cannot start a capsule
	task automatic send_noise();
		logic [3:0] nib;
		logic [3:0] low;
		nib = tracker.sync_a ^ 4'($urandom_range(15, 1));
		low = 4'($urandom());
		send_byte({nib, low}, now_us);
		now_us = now_us + $urandom_range(120, 40);
	endtask

	// good first byte, bad second byte; sometimes the second looks like a new first byte
	task automatic send_broken_pair();
		logic [3:0] nib;
		logic [3:0] low;
		low = 4'($urandom());
		send_byte({tracker.sync_a, low}, now_us);
		now_us = now_us + $urandom_range(120, 40);
		nib = tracker.sync_b ^ 4'($urandom_range(15, 1));
		if ($urandom_range(1) == 1 && tracker.sync_a != tracker.sync_b) begin
			nib = tracker.sync_a;
		end
		low = 4'($urandom());
		send_byte({nib, low}, now_us);
		now_us = now_us + $urandom_range(120, 40);
	endtask

	// a run of bytes that never gets past the second sync byte of a capsule
	task automatic send_junk(input int picks);
		for (int j = 0; j < picks; j++) begin
			if ($urandom_range(1) == 1) begin
				send_noise();
			end else begin
				send_broken_pair();
			end
		end
	endtask

	// drop valid, wait for every owed sample, then let the block settle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// write all four registers back to back
	task automatic cfg_apply(input logic [3:0] sync_first, input logic [3:0] sync_second,
			input logic [DIST_W-1:0] min_dist, input logic [DIST_W-1:0] max_dist);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SYNC_FIRST;
		cfg_data <= CFG_W'(sync_first);
		tracker.set_reg(CFG_SYNC_FIRST, CFG_W'(sync_first));
		@(posedge clk);
		cfg_index <= CFG_SYNC_SECOND;
		cfg_data <= CFG_W'(sync_second);
		tracker.set_reg(CFG_SYNC_SECOND, CFG_W'(sync_second));
		@(posedge clk);
		cfg_index <= CFG_MIN_DIST;
		cfg_data <= min_dist;
		tracker.set_reg(CFG_MIN_DIST, min_dist);
		@(posedge clk);
		cfg_index <= CFG_MAX_DIST;
		cfg_data <= max_dist;
		tracker.set_reg(CFG_MAX_DIST, max_dist);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [14:0] angle_raw;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no idling: sync handling, then a capsule that is only stored
		now_us = 32'hFFFF_F000;
		send_noise();
		send_broken_pair();
		send_broken_pair();
		build_capsule(15'd0);
		send_capsule();

		// sender mostly idle: all ones, start angle above a full turn, still only stored
		wait_quiet();
		cfg_apply(4'd15, 4'd0, 14'd2000, 14'd12000);
		send_idle_pct = 87;
		recv_stall_pct = 0;
		send_junk(JUNK_PICKS);
		build_capsule(15'h7FFF);
		for (int i = HDR_BYTES; i < CAPSULE_BYTES; i++) begin
			cap_buf[i] = 8'hFF;
		end
		cap_buf[0] = {tracker.sync_a, 4'hF};
		cap_buf[1] = {tracker.sync_b, 4'hF};
		cap_buf[3] = 8'hFF;
		send_capsule();

		// receiver mostly stalled: all-zero body with a backward start angle after a
		// time jump, decoding the all-ones capsule at the top distance limit
		wait_quiet();
		cfg_apply(4'd0, 4'd15, 14'd16383, 14'd16383);
		send_idle_pct = 0;
		recv_stall_pct = 87;
		send_junk(JUNK_PICKS);
		now_us = $urandom();
		build_capsule(15'd6400);
		for (int i = HDR_BYTES; i < CAPSULE_BYTES; i++) begin
			cap_buf[i] = 8'h00;
		end
		send_capsule();

		// both sides idle now and then: random start angle, inverted limits
		wait_quiet();
		cfg_apply(4'd3, 4'd12, 14'd16383, 14'd0);
		send_idle_pct = 32;
		recv_stall_pct = 32;
		send_junk(JUNK_PICKS);
		angle_raw = 15'($urandom_range(32767));
		build_capsule(angle_raw);
		send_capsule();

		wait_quiet();
		if (tracker.mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lecd_pkg.sv
hdl/lecd_ctrl.sv
hdl/lecd_datapath.sv
hdl/lidar_express_capsule_decoder_unit.sv
sim/capsule_decode_tracker_pkg.sv
sim/testbench.sv
